// ===== src/tdmrs_pkg.sv =====
// Shared types, codes and route key helpers for the TDM route scheduler.
package tdmrs_pkg;

    localparam int KEY_W  = 16;
    localparam int SLOT_W = KEY_W + 1;
    localparam int DIST_W = 7;
    localparam int CNT_W  = 12;
    localparam int SLEN_W = 13;

    typedef logic [KEY_W-1:0] t_key;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] MODE_LONG  = 2'd0;
    localparam logic [1:0] MODE_SHORT = 2'd1;
    localparam logic [1:0] MODE_NC    = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [2:0] DIR_NONE = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR_SWEEP,
        S_RUN_SWEEP,
        S_LOAD_SCAN,
        S_LOAD_END,
        S_READ,
        S_SEL,
        S_PICK,
        S_TSTART,
        S_TSCAN,
        S_PLACE,
        S_REM
    } t_state;

    function automatic logic [2:0] key_da(input t_key k);
        return k[15:13];
    endfunction

    function automatic logic [4:0] key_la(input t_key k);
        return k[12:8];
    endfunction

    function automatic logic [2:0] key_db(input t_key k);
        return k[7:5];
    endfunction

    function automatic logic [4:0] key_lb(input t_key k);
        return k[4:0];
    endfunction

    function automatic logic [5:0] key_len(input t_key k);
        return {1'b0, k[12:8]} + {1'b0, k[4:0]};
    endfunction

endpackage

// ===== src/tdmrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tdmrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tdmrs_conflict.sv =====
// Conflict offset check between an earlier route a and a later route b.
module tdmrs_conflict (
    input  tdmrs_pkg::t_key              i_key_a,
    input  tdmrs_pkg::t_key              i_key_b,
    input  logic [tdmrs_pkg::DIST_W-1:0] i_dist,
    output logic                         o_hit,
    output logic                         o_only_zero
);

    always_comb begin
        logic signed [7:0] ala, alb, bla, blb, d, t1, t3, x;
        logic [2:0]        ada, adb, bda, bdb;
        logic signed [7:0] lo [4];
        logic signed [7:0] hi [4];
        logic              en [4];
        logic              ok;

        ada = tdmrs_pkg::key_da(i_key_a);
        adb = tdmrs_pkg::key_db(i_key_a);
        bda = tdmrs_pkg::key_da(i_key_b);
        bdb = tdmrs_pkg::key_db(i_key_b);
        ala = $signed({3'b000, tdmrs_pkg::key_la(i_key_a)});
        alb = $signed({3'b000, tdmrs_pkg::key_lb(i_key_a)});
        bla = $signed({3'b000, tdmrs_pkg::key_la(i_key_b)});
        blb = $signed({3'b000, tdmrs_pkg::key_lb(i_key_b)});
        d   = $signed({1'b0, i_dist});

        // same slot always collides
        en[0] = 1'b1;
        lo[0] = 8'sd0;
        hi[0] = 8'sd0;

        // first-leg overlap
        en[1] = 1'b0;
        lo[1] = 8'sd0;
        hi[1] = 8'sd0;
        if (ada == bda) begin
            en[1] = 1'b1;
            hi[1] = ala - 8'sd1;
        end else if (ada == bdb && blb != 8'sd0 && (ala - bla - 8'sd1) > 8'sd0) begin
            en[1] = 1'b1;
            hi[1] = ala - bla - 8'sd1;
        end

        // second-leg overlap
        en[2] = 1'b0;
        lo[2] = 8'sd0;
        hi[2] = 8'sd0;
        t1 = ala + alb - bla - 8'sd1;
        if (adb == bdb && alb != 8'sd0 && blb != 8'sd0 && t1 > 8'sd0) begin
            x     = ala - bla - blb + 8'sd1;
            en[2] = 1'b1;
            lo[2] = (x > 8'sd0) ? x : 8'sd0;
            hi[2] = t1;
        end else if (adb == bda && alb != 8'sd0) begin
            x     = ala - bla + 8'sd1;
            en[2] = 1'b1;
            lo[2] = (x > 8'sd0) ? x : 8'sd0;
            hi[2] = ala + alb - 8'sd1;
        end else begin
            x = 8'sd0;
        end

        // arrival difference
        t3    = ala + alb - bla - blb;
        en[3] = (t3 > 8'sd0);
        lo[3] = t3;
        hi[3] = t3;

        o_hit       = 1'b0;
        o_only_zero = 1'b1;
        for (int j = 0; j < 4; j++) begin
            ok = en[j] && (lo[j] <= hi[j]);
            if (ok && lo[j] <= d && d <= hi[j]) begin
                o_hit = 1'b1;
            end
            if (ok && hi[j] > 8'sd0) begin
                o_only_zero = 1'b0;
            end
        end
    end

endmodule

// ===== src/tdm_route_pattern_scheduler.sv =====
// Top level: greedy TDM route scheduler with route, pending and slot tables.
// Load scans the route table for a duplicate and clear sweeps the whole slot table;
// the one-cycle o_done beat follows the last step and the receiver cannot stall it.
// A run sweeps max(MAX_SLOTS, MAX_ROUTES) entries, then per pick walks the route table twice, plus
// a slot table window scan per tried slot (single slot table read port). Busy for the whole item.
// Reset (sync, active low) starts a slot table clearing pass over all MAX_SLOTS entries with busy high.
module tdm_route_pattern_scheduler #(
    parameter int MAX_ROUTES = 2048,
    parameter int MAX_SLOTS  = 4096,
    parameter int MAX_HOPS   = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_first_dir,
    input  logic [4:0]  i_first_len,
    input  logic [2:0]  i_second_dir,
    input  logic [4:0]  i_second_len,
    input  logic [11:0] i_slot_index,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [11:0] o_pattern_count,
    output logic [12:0] o_schedule_length,
    output logic        o_slot_valid,
    output logic [2:0]  o_slot_first_dir,
    output logic [4:0]  o_slot_first_len,
    output logic [2:0]  o_slot_second_dir,
    output logic [4:0]  o_slot_second_len
);

    localparam int RA      = $clog2(MAX_ROUTES);
    localparam int SA      = $clog2(MAX_SLOTS);
    localparam int RCW     = $clog2(MAX_ROUTES + 1);
    localparam int TW      = $clog2(MAX_SLOTS + 1);
    localparam int SWEEP_N = (MAX_SLOTS > MAX_ROUTES) ? MAX_SLOTS : MAX_ROUTES;
    localparam int SWW     = $clog2(SWEEP_N);
    localparam int WIN     = 2 * MAX_HOPS;

    // control state
    tdmrs_pkg::t_state r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [RCW-1:0]    r_route_total, n_route_total;
    logic [RCW-1:0]    r_placed, n_placed;
    logic [TW-1:0]     r_len, n_len;
    tdmrs_pkg::t_key   r_last, n_last;
    logic [SWW-1:0]    r_swp, n_swp;
    logic              r_reply, n_reply;
    logic              r_rv, n_rv;
    logic              r_done, n_done;

    // working registers
    tdmrs_pkg::t_key   r_key, n_key;
    tdmrs_pkg::t_key   r_pick, n_pick;
    tdmrs_pkg::t_key   r_best, n_best;
    tdmrs_pkg::t_key   r_best_nc, n_best_nc;
    logic              r_have, n_have;
    logic              r_have_nc, n_have_nc;
    logic              r_dup, n_dup;
    logic [RCW-1:0]    r_idx, n_idx;
    logic [RA-1:0]     r_id, n_id;
    logic [TW-1:0]     r_t, n_t;
    logic [TW-1:0]     r_u, n_u;
    logic [TW-1:0]     r_ud, n_ud;

    // result registers
    logic [1:0]                   r_status, n_status;
    logic [tdmrs_pkg::CNT_W-1:0]  r_count, n_count;
    logic [tdmrs_pkg::SLEN_W-1:0] r_slen, n_slen;
    logic                         r_sv, n_sv;
    tdmrs_pkg::t_key              r_skey, n_skey;

    // memories
    logic                         route_we;
    logic [RA-1:0]                route_waddr;
    tdmrs_pkg::t_key              route_rdata;
    logic                         pend_we;
    logic [RA-1:0]                pend_waddr;
    logic                         pend_wdata;
    logic                         pend_rdata;
    logic                         slot_we;
    logic [SA-1:0]                slot_waddr;
    logic [tdmrs_pkg::SLOT_W-1:0] slot_wdata;
    logic [SA-1:0]                slot_raddr;
    logic [tdmrs_pkg::SLOT_W-1:0] slot_rdata;

    // shared conflict unit
    tdmrs_pkg::t_key              c_a, c_b;
    logic [tdmrs_pkg::DIST_W-1:0] c_dist;
    logic                         c_hit, c_only_zero;

    // shared conditions
    logic            w_accept;
    logic [1:0]      w_mode;
    logic [4:0]      w_fl, w_sl_s, w_sl;
    logic [2:0]      w_sd;
    logic            w_load_bad;
    logic            w_read_oor;
    logic            w_idx_issue;
    logic            w_scan_done;
    logic            w_t_ok;
    logic [TW-1:0]   w_lo, w_hi;
    logic [TW:0]     w_tw_sum;
    logic            w_u_issue;
    logic            w_u_before;
    logic            w_conflict;
    logic [TW:0]     w_tend;
    logic            w_fit_fail;
    tdmrs_pkg::t_key w_inv;
    tdmrs_pkg::t_key w_choice;
    logic            w_swp_in_routes;
    logic            w_swp_in_slots;

    function automatic logic [4:0] sat_len(input logic [4:0] v);
        return ({1'b0, v} > 6'(MAX_HOPS)) ? 5'(MAX_HOPS) : v;
    endfunction

    function automatic logic better(input logic shortest, input tdmrs_pkg::t_key k,
                                    input tdmrs_pkg::t_key b);
        logic [5:0] kl, bl;
        kl = tdmrs_pkg::key_len(k);
        bl = tdmrs_pkg::key_len(b);
        if (kl == bl) begin
            return k < b;
        end
        return shortest ? (kl < bl) : (kl > bl);
    endfunction

    assign busy     = (r_state != tdmrs_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_mode   = (r_mode == tdmrs_pkg::MODE_RSVD) ? tdmrs_pkg::MODE_LONG : r_mode;

    assign w_fl       = sat_len(i_first_len);
    assign w_sl_s     = sat_len(i_second_len);
    assign w_sd       = (w_sl_s == 5'd0) ? tdmrs_pkg::DIR_NONE : i_second_dir;
    assign w_sl       = (w_sd == tdmrs_pkg::DIR_NONE) ? 5'd0 : w_sl_s;
    assign w_load_bad = (i_first_dir == tdmrs_pkg::DIR_NONE) || (w_fl == 5'd0);
    assign w_read_oor = (32'(i_slot_index) >= 32'(MAX_SLOTS));

    assign w_idx_issue = (r_idx < r_route_total);
    assign w_scan_done = !w_idx_issue && !r_rv;
    assign w_t_ok      = (r_t <= r_len) && (r_t < TW'(MAX_SLOTS));

    // conflict window around the candidate slot
    assign w_lo      = (r_t > TW'(WIN)) ? (r_t - TW'(WIN)) : '0;
    assign w_tw_sum  = {1'b0, r_t} + (TW+1)'(WIN);
    assign w_hi      = (w_tw_sum < (TW+1)'(MAX_SLOTS)) ? w_tw_sum[TW-1:0] : TW'(MAX_SLOTS - 1);
    assign w_u_issue = (r_u <= w_hi);

    assign w_u_before = (r_ud < r_t);
    assign w_conflict = r_rv && slot_rdata[tdmrs_pkg::KEY_W] && ((r_ud == r_t) || c_hit);

    assign w_tend     = {1'b0, r_t} + (TW+1)'(tdmrs_pkg::key_len(r_pick));
    assign w_fit_fail = (w_tend > (TW+1)'(MAX_SLOTS));

    assign w_inv = (tdmrs_pkg::key_lb(r_pick) == 5'd0) ? r_pick :
                   {tdmrs_pkg::key_db(r_pick), tdmrs_pkg::key_lb(r_pick),
                    tdmrs_pkg::key_da(r_pick), tdmrs_pkg::key_la(r_pick)};

    assign w_choice = (w_mode == tdmrs_pkg::MODE_NC && r_have_nc) ? r_best_nc : r_best;

    assign w_swp_in_routes = ((SWW+1)'(r_swp) < (SWW+1)'(MAX_ROUTES));
    assign w_swp_in_slots  = ((SWW+1)'(r_swp) < (SWW+1)'(MAX_SLOTS));

    // conflict unit operands: last pick during selection, placed route during slot search
    always_comb begin
        if (r_state == tdmrs_pkg::S_TSCAN) begin
            c_a    = w_u_before ? slot_rdata[tdmrs_pkg::KEY_W-1:0] : r_pick;
            c_b    = w_u_before ? r_pick : slot_rdata[tdmrs_pkg::KEY_W-1:0];
            c_dist = w_u_before ? tdmrs_pkg::DIST_W'(r_t - r_ud)
                                : tdmrs_pkg::DIST_W'(r_ud - r_t);
        end else begin
            c_a    = r_last;
            c_b    = route_rdata;
            c_dist = '0;
        end
    end

    tdmrs_conflict u_conflict (
        .i_key_a     (c_a),
        .i_key_b     (c_b),
        .i_dist      (c_dist),
        .o_hit       (c_hit),
        .o_only_zero (c_only_zero)
    );

    tdmrs_ram #(.WIDTH(tdmrs_pkg::KEY_W), .DEPTH(MAX_ROUTES)) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (route_we),
        .i_waddr (route_waddr),
        .i_wdata (r_key),
        .i_raddr (r_idx[RA-1:0]),
        .o_rdata (route_rdata)
    );

    tdmrs_ram #(.WIDTH(1), .DEPTH(MAX_ROUTES)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (r_idx[RA-1:0]),
        .o_rdata (pend_rdata)
    );

    tdmrs_ram #(.WIDTH(tdmrs_pkg::SLOT_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdmrs_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        tdmrs_pkg::CMD_LOAD: begin
                            if (!w_load_bad) n_state = tdmrs_pkg::S_LOAD_SCAN;
                        end
                        tdmrs_pkg::CMD_RUN: n_state = tdmrs_pkg::S_RUN_SWEEP;
                        tdmrs_pkg::CMD_READ: begin
                            if (!w_read_oor) n_state = tdmrs_pkg::S_READ;
                        end
                        tdmrs_pkg::CMD_CLEAR: n_state = tdmrs_pkg::S_CLR_SWEEP;
                        default: ;
                    endcase
                end
            end
            tdmrs_pkg::S_CLR_SWEEP: begin
                if (r_swp == SWW'(MAX_SLOTS - 1)) n_state = tdmrs_pkg::S_IDLE;
            end
            tdmrs_pkg::S_RUN_SWEEP: begin
                if (r_swp == SWW'(SWEEP_N - 1)) n_state = tdmrs_pkg::S_SEL;
            end
            tdmrs_pkg::S_LOAD_SCAN: begin
                if (w_scan_done) n_state = tdmrs_pkg::S_LOAD_END;
            end
            tdmrs_pkg::S_LOAD_END: n_state = tdmrs_pkg::S_IDLE;
            tdmrs_pkg::S_READ:     n_state = tdmrs_pkg::S_IDLE;
            tdmrs_pkg::S_SEL: begin
                if (w_scan_done) n_state = tdmrs_pkg::S_PICK;
            end
            tdmrs_pkg::S_PICK: begin
                if (!r_have) begin
                    n_state = tdmrs_pkg::S_IDLE;
                end else if (r_placed == '0) begin
                    n_state = tdmrs_pkg::S_PLACE;
                end else begin
                    n_state = tdmrs_pkg::S_TSTART;
                end
            end
            tdmrs_pkg::S_TSTART: begin
                n_state = w_t_ok ? tdmrs_pkg::S_TSCAN : tdmrs_pkg::S_IDLE;
            end
            tdmrs_pkg::S_TSCAN: begin
                if (w_conflict) begin
                    n_state = tdmrs_pkg::S_TSTART;
                end else if (!w_u_issue && !r_rv) begin
                    n_state = tdmrs_pkg::S_PLACE;
                end
            end
            tdmrs_pkg::S_PLACE: begin
                n_state = w_fit_fail ? tdmrs_pkg::S_IDLE : tdmrs_pkg::S_REM;
            end
            tdmrs_pkg::S_REM: begin
                if (w_scan_done) n_state = tdmrs_pkg::S_SEL;
            end
            default: n_state = tdmrs_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        route_we    = 1'b0;
        route_waddr = r_route_total[RA-1:0];
        pend_we     = 1'b0;
        pend_waddr  = r_id;
        pend_wdata  = 1'b0;
        slot_we     = 1'b0;
        slot_waddr  = r_swp[SA-1:0];
        slot_wdata  = '0;
        slot_raddr  = r_u[SA-1:0];
        case (r_state)
            tdmrs_pkg::S_IDLE: begin
                slot_raddr = SA'(i_slot_index);
            end
            tdmrs_pkg::S_CLR_SWEEP: begin
                slot_we = 1'b1;
            end
            tdmrs_pkg::S_RUN_SWEEP: begin
                slot_we    = w_swp_in_slots;
                pend_we    = w_swp_in_routes;
                pend_waddr = r_swp[RA-1:0];
                pend_wdata = ((SWW+1)'(r_swp) < (SWW+1)'(r_route_total));
            end
            tdmrs_pkg::S_LOAD_END: begin
                route_we = !r_dup && (r_route_total < RCW'(MAX_ROUTES));
            end
            tdmrs_pkg::S_PLACE: begin
                slot_we    = !w_fit_fail;
                slot_waddr = r_t[SA-1:0];
                slot_wdata = {1'b1, r_pick};
            end
            tdmrs_pkg::S_REM: begin
                pend_we = r_rv && (route_rdata == r_pick || route_rdata == w_inv);
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_mode        = i_cfg_we ? i_cfg_wdata : r_mode;
        n_route_total = r_route_total;
        n_placed      = r_placed;
        n_len         = r_len;
        n_last        = r_last;
        n_swp         = r_swp;
        n_reply       = r_reply;
        n_rv          = r_rv;
        n_done        = 1'b0;
        n_key         = r_key;
        n_pick        = r_pick;
        n_best        = r_best;
        n_best_nc     = r_best_nc;
        n_have        = r_have;
        n_have_nc     = r_have_nc;
        n_dup         = r_dup;
        n_idx         = r_idx;
        n_id          = r_id;
        n_t           = r_t;
        n_u           = r_u;
        n_ud          = r_ud;
        n_status      = r_status;
        n_count       = r_count;
        n_slen        = tdmrs_pkg::SLEN_W'(r_len);
        n_sv          = 1'b0;
        n_skey        = '0;

        // sequential table walk shared by load, selection and removal
        if (r_state == tdmrs_pkg::S_LOAD_SCAN || r_state == tdmrs_pkg::S_SEL ||
            r_state == tdmrs_pkg::S_REM) begin
            if (w_idx_issue) begin
                n_idx = r_idx + 1'b1;
                n_id  = r_idx[RA-1:0];
                n_rv  = 1'b1;
            end else begin
                n_rv = 1'b0;
            end
        end

        case (r_state)
            tdmrs_pkg::S_IDLE: begin
                n_count = tdmrs_pkg::CNT_W'(r_route_total);
                if (w_accept) begin
                    n_idx = '0;
                    n_rv  = 1'b0;
                    n_swp = '0;
                    case (i_cmd)
                        tdmrs_pkg::CMD_LOAD: begin
                            n_key = {i_first_dir, w_fl, w_sd, w_sl};
                            n_dup = 1'b0;
                            if (w_load_bad) begin
                                n_done   = 1'b1;
                                n_status = tdmrs_pkg::ST_DROP;
                            end
                        end
                        tdmrs_pkg::CMD_RUN: begin
                            n_len    = '0;
                            n_last   = '0;
                            n_placed = '0;
                        end
                        tdmrs_pkg::CMD_READ: begin
                            if (w_read_oor) begin
                                n_done   = 1'b1;
                                n_status = tdmrs_pkg::ST_RANGE;
                            end
                        end
                        tdmrs_pkg::CMD_CLEAR: begin
                            n_route_total = '0;
                            n_len         = '0;
                            n_last        = '0;
                            n_placed      = '0;
                            n_reply       = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            tdmrs_pkg::S_CLR_SWEEP: begin
                n_swp = r_swp + 1'b1;
                if (r_swp == SWW'(MAX_SLOTS - 1)) begin
                    n_swp    = '0;
                    n_reply  = 1'b0;
                    n_done   = r_reply;
                    n_status = tdmrs_pkg::ST_OK;
                    n_count  = '0;
                end
            end
            tdmrs_pkg::S_RUN_SWEEP: begin
                n_swp = r_swp + 1'b1;
                if (r_swp == SWW'(SWEEP_N - 1)) begin
                    n_swp     = '0;
                    n_idx     = '0;
                    n_rv      = 1'b0;
                    n_have    = 1'b0;
                    n_have_nc = 1'b0;
                end
            end
            tdmrs_pkg::S_LOAD_SCAN: begin
                if (r_rv && route_rdata == r_key) n_dup = 1'b1;
            end
            tdmrs_pkg::S_LOAD_END: begin
                n_done = 1'b1;
                if (r_dup) begin
                    n_status = tdmrs_pkg::ST_DROP;
                end else if (r_route_total >= RCW'(MAX_ROUTES)) begin
                    n_status = tdmrs_pkg::ST_FULL;
                end else begin
                    n_status      = tdmrs_pkg::ST_OK;
                    n_route_total = r_route_total + 1'b1;
                end
                n_count = tdmrs_pkg::CNT_W'(n_route_total);
            end
            tdmrs_pkg::S_READ: begin
                n_done   = 1'b1;
                n_status = tdmrs_pkg::ST_OK;
                n_count  = tdmrs_pkg::CNT_W'(r_route_total);
                n_sv     = slot_rdata[tdmrs_pkg::KEY_W];
                n_skey   = slot_rdata[tdmrs_pkg::KEY_W] ?
                           slot_rdata[tdmrs_pkg::KEY_W-1:0] : '0;
            end
            tdmrs_pkg::S_SEL: begin
                if (r_rv && pend_rdata) begin
                    if (!r_have || better(w_mode == tdmrs_pkg::MODE_SHORT, route_rdata, r_best))
                    begin
                        n_best = route_rdata;
                        n_have = 1'b1;
                    end
                    if (w_mode == tdmrs_pkg::MODE_NC && c_only_zero &&
                        (!r_have_nc || better(1'b0, route_rdata, r_best_nc))) begin
                        n_best_nc = route_rdata;
                        n_have_nc = 1'b1;
                    end
                end
            end
            tdmrs_pkg::S_PICK: begin
                n_pick = w_choice;
                if (w_mode == tdmrs_pkg::MODE_NC) n_last = w_choice;
                n_t = (r_placed == '0) ? '0 : TW'(1);
                if (!r_have) begin
                    n_done   = 1'b1;
                    n_status = tdmrs_pkg::ST_OK;
                    n_count  = tdmrs_pkg::CNT_W'(r_placed);
                end
            end
            tdmrs_pkg::S_TSTART: begin
                n_u  = w_lo;
                n_rv = 1'b0;
                if (!w_t_ok) begin
                    n_done   = 1'b1;
                    n_status = tdmrs_pkg::ST_RANGE;
                    n_count  = tdmrs_pkg::CNT_W'(r_placed);
                end
            end
            tdmrs_pkg::S_TSCAN: begin
                if (w_conflict) begin
                    n_t  = r_t + 1'b1;
                    n_rv = 1'b0;
                end else if (w_u_issue) begin
                    n_u  = r_u + 1'b1;
                    n_ud = r_u;
                    n_rv = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
            end
            tdmrs_pkg::S_PLACE: begin
                if (w_fit_fail) begin
                    n_done   = 1'b1;
                    n_status = tdmrs_pkg::ST_RANGE;
                    n_count  = tdmrs_pkg::CNT_W'(r_placed);
                end else begin
                    n_placed = r_placed + 1'b1;
                    if (w_tend > {1'b0, r_len}) n_len = w_tend[TW-1:0];
                    n_idx = '0;
                    n_rv  = 1'b0;
                end
            end
            tdmrs_pkg::S_REM: begin
                if (w_scan_done) begin
                    n_idx     = '0;
                    n_have    = 1'b0;
                    n_have_nc = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tdmrs_pkg::S_CLR_SWEEP;
            r_mode        <= tdmrs_pkg::MODE_LONG;
            r_route_total <= '0;
            r_placed      <= '0;
            r_len         <= '0;
            r_last        <= '0;
            r_swp         <= '0;
            r_reply       <= 1'b0;
            r_rv          <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_route_total <= n_route_total;
            r_placed      <= n_placed;
            r_len         <= n_len;
            r_last        <= n_last;
            r_swp         <= n_swp;
            r_reply       <= n_reply;
            r_rv          <= n_rv;
            r_done        <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_pick    <= n_pick;
        r_best    <= n_best;
        r_best_nc <= n_best_nc;
        r_have    <= n_have;
        r_have_nc <= n_have_nc;
        r_dup     <= n_dup;
        r_idx     <= n_idx;
        r_id      <= n_id;
        r_t       <= n_t;
        r_u       <= n_u;
        r_ud      <= n_ud;
        r_status  <= n_status;
        r_count   <= n_count;
        r_slen    <= n_slen;
        r_sv      <= n_sv;
        r_skey    <= n_skey;
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_pattern_count   = r_count;
    assign o_schedule_length = r_slen;
    assign o_slot_valid      = r_sv;
    assign o_slot_first_dir  = tdmrs_pkg::key_da(r_skey);
    assign o_slot_first_len  = tdmrs_pkg::key_la(r_skey);
    assign o_slot_second_dir = tdmrs_pkg::key_db(r_skey);
    assign o_slot_second_len = tdmrs_pkg::key_lb(r_skey);

`ifndef ASSERT_OFF
    // a result beat always coincides with the sequencer being back in idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !busy)
        else $error("result beat while busy");

    // every placed route came out of the route table
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_placed <= r_route_total)
        else $error("placed count exceeds route count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_len <= TW'(MAX_SLOTS))
        else $error("schedule length beyond slot table");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_route_total <= RCW'(MAX_ROUTES))
        else $error("route count beyond table depth");

    // apart from the first placement of a run, a slot is only written after the candidate search cleared it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdmrs_pkg::S_PLACE && r_placed != '0) |-> $past(r_state == tdmrs_pkg::S_TSCAN))
        else $error("placement without slot search");
`endif

endmodule
